// ===== rtl/tcpc_pkg.sv =====
// shared types and constants of the tcp pseudo-header checksum unit
`timescale 1ns / 1ps
package tcpc_pkg;

	localparam int MAX_SEGMENT_BYTES = 65535;
	localparam int CNT_W = 17;
	localparam int LEN_W = 16;
	localparam int ASUM_W = 18;

	localparam logic [CNT_W-1:0] CNT_SAT = CNT_W'(MAX_SEGMENT_BYTES + 1);
	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_SEGMENT_BYTES);

	localparam int Q_AW = 1;
	localparam int Q_DEPTH = 1 << Q_AW;

	localparam int PADDR_W = 3;
	localparam logic REG_PROTOCOL = 1'b0;
	localparam logic REG_ZERO_TO_ONES = 1'b1;

	localparam logic [7:0] PROTOCOL_RESET = 8'd6;
	localparam logic ZERO_TO_ONES_RESET = 1'b1;

	typedef struct packed {
		logic [15:0]       seg_sum;
		logic [ASUM_W-1:0] addr_sum;
		logic [LEN_W-1:0]  seg_len;
		logic              over;
	} seg_rec_t;

	typedef struct packed {
		logic [7:0] protocol;
		logic       zero_to_ones;
	} cfg_t;

endpackage

// ===== rtl/tcpc_front.sv =====
// front end: accepts segment words, keeps running sum, byte count and address sum
`timescale 1ns / 1ps
module tcpc_front import tcpc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [15:0]       data_word,
	input  logic              first_item,
	input  logic              last_item,
	input  logic              single_byte,
	input  logic [31:0]       source_address,
	input  logic [31:0]       dest_address,
	input  logic              q_full,
	output logic              q_push,
	output seg_rec_t          q_rec
);

	logic [15:0]       sum_q;
	logic [CNT_W-1:0]  count_q;
	logic [ASUM_W-1:0] addr_q;

	logic [15:0]       sum_base;
	logic [CNT_W-1:0]  count_base;
	logic [ASUM_W-1:0] addr_next;
	logic [15:0]       word;
	logic [16:0]       sum_wide;
	logic [15:0]       sum_next;
	logic [CNT_W:0]    count_wide;
	logic [CNT_W-1:0]  count_next;
	logic              over;
	logic              xfer;

	assign in_ready = !q_full;
	assign xfer = in_valid && in_ready;

	always_comb begin
		sum_base = first_item ? 16'd0 : sum_q;
		count_base = first_item ? '0 : count_q;
		addr_next = first_item
			? (ASUM_W'(source_address[31:16]) + ASUM_W'(source_address[15:0])
				+ ASUM_W'(dest_address[31:16]) + ASUM_W'(dest_address[15:0]))
			: addr_q;
		word = (last_item && single_byte) ? {data_word[15:8], 8'h00} : data_word;
		sum_wide = {1'b0, sum_base} + {1'b0, word};
		sum_next = sum_wide[15:0] + {15'd0, sum_wide[16]};
		count_wide = {1'b0, count_base}
			+ ((last_item && single_byte) ? (CNT_W+1)'(1) : (CNT_W+1)'(2));
		count_next = (count_wide > {1'b0, CNT_SAT}) ? CNT_SAT : count_wide[CNT_W-1:0];
		over = count_next > CNT_W'(MAX_SEGMENT_BYTES);
		q_rec.seg_sum = sum_next;
		q_rec.addr_sum = addr_next;
		q_rec.seg_len = over ? LEN_MAX : count_next[LEN_W-1:0];
		q_rec.over = over;
	end

	assign q_push = xfer && last_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			count_q <= '0;
			addr_q <= '0;
		end else if (xfer) begin
			addr_q <= addr_next;
			if (last_item) begin
				sum_q <= '0;
				count_q <= '0;
			end else begin
				sum_q <= sum_next;
				count_q <= count_next;
			end
		end
	end

endmodule

// ===== rtl/tcpc_queue.sv =====
// short queue of finished segment records between front and back
`timescale 1ns / 1ps
module tcpc_queue import tcpc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  seg_rec_t push_rec,
	output logic     full,
	input  logic     pop,
	output logic     not_empty,
	output seg_rec_t pop_rec
);

	seg_rec_t          mem_q [Q_DEPTH];
	logic [Q_AW-1:0]   wr_q;
	logic [Q_AW-1:0]   rd_q;
	logic [Q_AW:0]     fill_q;

	assign full = fill_q == (Q_AW+1)'(Q_DEPTH);
	assign not_empty = fill_q != '0;
	assign pop_rec = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/tcpc_back.sv =====
// back end: adds the pseudo-header, folds, complements and holds the result
`timescale 1ns / 1ps
module tcpc_back import tcpc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic             q_not_empty,
	input  seg_rec_t         q_rec,
	output logic             q_pop,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [15:0]      checksum,
	output logic [LEN_W-1:0] segment_bytes,
	output logic             length_overflow
);

	logic              valid_q;
	logic [15:0]       ck_q;
	logic [LEN_W-1:0]  len_q;
	logic              over_q;

	logic [18:0] total;
	logic [16:0] fold1;
	logic [15:0] fold2;
	logic [15:0] ck;

	always_comb begin
		total = 19'(q_rec.seg_sum) + 19'(q_rec.addr_sum) + 19'(cfg.protocol)
			+ 19'(q_rec.seg_len);
		fold1 = {1'b0, total[15:0]} + {14'd0, total[18:16]};
		fold2 = fold1[15:0] + {15'd0, fold1[16]};
		ck = ~fold2;
		if (ck == 16'd0 && cfg.zero_to_ones) begin
			ck = 16'hffff;
		end
	end

	assign q_pop = q_not_empty && (!valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || out_ready) begin
			valid_q <= q_not_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			ck_q <= ck;
			len_q <= q_rec.seg_len;
			over_q <= q_rec.over;
		end
	end

	assign out_valid = valid_q;
	assign checksum = ck_q;
	assign segment_bytes = len_q;
	assign length_overflow = over_q;

endmodule

// ===== rtl/tcp_pseudo_header_checksum_unit.sv =====
// top level of the tcp pseudo-header checksum unit with its register port
//
// Input channel (in_valid/in_ready): one big-endian 16-bit segment word per
// transfer, with first_item, last_item, single_byte and the IPv4 addresses,
// which are taken on a first word. The checksum field must already be zero.
// Output channel (out_valid/out_ready): one result per last word, carrying
// the checksum, the counted segment length (saturated at 65535) and an
// overflow flag.
// Throughput: one word per cycle while the record queue is not full, set
// by the sum and count update in the front end. The result of a last
// word is written into a two-entry record queue and then moved into the
// output register in the back end, which drives out_valid.
// When the receiver stalls, the queue and output register hold up to three
// results; after that in_ready drops until the receiver takes one.
// Reset clears the sums, the byte count, the queue and the output valid and
// sets protocol_number to 6 and zero_to_ones_enable to 1.
// Registers: 0x0 protocol_number [7:0], 0x4 zero_to_ones_enable [0].
`timescale 1ns / 1ps
module tcp_pseudo_header_checksum_unit import tcpc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [15:0]        data_word,
	input  logic               first_item,
	input  logic               last_item,
	input  logic               single_byte,
	input  logic [31:0]        source_address,
	input  logic [31:0]        dest_address,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [15:0]        checksum,
	output logic [15:0]        segment_bytes,
	output logic               length_overflow
);

	cfg_t     cfg_q;
	logic     q_full;
	logic     q_push;
	logic     q_pop;
	logic     q_not_empty;
	seg_rec_t push_rec;
	seg_rec_t pop_rec;
	logic     reg_idx;

	assign pready = 1'b1;
	assign reg_idx = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.protocol <= PROTOCOL_RESET;
			cfg_q.zero_to_ones <= ZERO_TO_ONES_RESET;
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx)
				REG_PROTOCOL: cfg_q.protocol <= pwdata[7:0];
				REG_ZERO_TO_ONES: cfg_q.zero_to_ones <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_PROTOCOL: prdata = {24'd0, cfg_q.protocol};
			REG_ZERO_TO_ONES: prdata = {31'd0, cfg_q.zero_to_ones};
			default: prdata = '0;
		endcase
	end

	tcpc_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.data_word      (data_word),
		.first_item     (first_item),
		.last_item      (last_item),
		.single_byte    (single_byte),
		.source_address (source_address),
		.dest_address   (dest_address),
		.q_full         (q_full),
		.q_push         (q_push),
		.q_rec          (push_rec)
	);

	tcpc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_rec  (push_rec),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.pop_rec   (pop_rec)
	);

	tcpc_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg_q),
		.q_not_empty     (q_not_empty),
		.q_rec           (pop_rec),
		.q_pop           (q_pop),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.checksum        (checksum),
		.segment_bytes   (segment_bytes),
		.length_overflow (length_overflow)
	);

endmodule
